// ===== hw/rtl/nwt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwt_pkg
// Shared widths, token codes and division constants for the number-to-word
// token unit.
// ----------------------------------------------------------------------------
package nwt_pkg;

    localparam int VALUE_W   = 21;
    localparam int S_DATA_W  = 24;
    localparam int TOKEN_W   = 6;
    localparam int M_DATA_W  = 8;
    localparam int THOUS_W   = 11;   // magnitude / 1000 reaches 1048
    localparam int REM_W     = 10;   // magnitude % 1000
    localparam int DIGIT_W   = 4;
    localparam int R2_W      = 7;    // remainder below one hundred
    localparam int UNIT_W    = 5;    // one to nineteen

    // Token codes; group tokens are a base plus the digit or value.
    localparam logic [TOKEN_W-1:0] TOK_NEGATIVE      = 6'd0;
    localparam logic [TOKEN_W-1:0] TOK_ZERO          = 6'd1;
    localparam logic [TOKEN_W-1:0] TOK_THOUSAND_BASE = 6'd1;
    localparam logic [TOKEN_W-1:0] TOK_HUNDRED_BASE  = 6'd10;
    localparam logic [TOKEN_W-1:0] TOK_TENS_BASE     = 6'd18;
    localparam logic [TOKEN_W-1:0] TOK_UNIT_BASE     = 6'd27;
    localparam logic [TOKEN_W-1:0] TOK_MAX           = 6'd46;

    // Token slots in spoken order.
    localparam int SLOT_NEG   = 0;
    localparam int SLOT_ZERO  = 1;
    localparam int SLOT_THOUS = 2;
    localparam int SLOT_HUND  = 3;
    localparam int SLOT_TENS  = 4;
    localparam int SLOT_UNIT  = 5;
    localparam int NUM_SLOTS  = 6;

    // Reciprocal division constants. Each is exact over the operand range used.
    localparam int RECIP_1000_SHIFT = 30;
    localparam logic [20:0] RECIP_1000 = 21'd1073742;   // ceil(2^30 / 1000)
    localparam int RECIP_100_SHIFT  = 12;
    localparam logic [5:0]  RECIP_100  = 6'd41;          // valid for 0..999
    localparam int RECIP_10_SHIFT   = 11;
    localparam logic [7:0]  RECIP_10   = 8'd205;         // valid for 0..99

    localparam logic [9:0]  K_THOUSAND = 10'd1000;
    localparam logic [6:0]  K_HUNDRED  = 7'd100;
    localparam logic [3:0]  K_TEN      = 4'd10;
    localparam logic [4:0]  K_TEEN_MAX = 5'd19;

endpackage

// ===== hw/rtl/number_to_word_tokens_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_to_word_tokens_unit
// Turns a signed integer into the word tokens that name it, in spoken order.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one 21-bit two's complement value in s_tdata[20:0].
//   Each value yields zero to five output beats, one token per beat, in
//   spoken order: negative, zero or thousands, hundreds, tens, units/teens.
//   m_tlast marks the final token of a value. A value with a thousands count
//   above nine and zero low digits produces no beat at all (a negative one
//   produces only the negative token).
//   Tokens pass through stages 1 to 7 and the output register. Throughput:
//   one value per cycle when it yields at most one token and the receiver is
//   ready; a value with more tokens holds stage 7 until its last token is
//   sent. The seven-stage arithmetic pipeline takes a new value every cycle
//   unless stage 7 holds a value that cannot leave, which drops s_tready;
//   only the token serializer at its end limits the rate. A receiver stall
//   holds the output beat and freezes the pipeline once stage 7 holds a value.
//   Reset (aresetn low at a clock edge) empties all stages and the output.
// ----------------------------------------------------------------------------
module number_to_word_tokens_unit
    import nwt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [20:0] value, [23:21] zero
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [5:0] word_token, [7:6] zero
    output logic                m_tlast    // last_token
);

    // Stage 1: sign and magnitude.
    logic                v1_reg;
    logic                neg1_reg;
    logic [VALUE_W-1:0]  mag1_reg;
    // Stage 2: magnitude times reciprocal of 1000.
    logic                v2_reg;
    logic                neg2_reg;
    logic [VALUE_W-1:0]  mag2_reg;
    logic [THOUS_W-1:0]  th2_reg;
    // Stage 3: remainder mod 1000 and thousands digit.
    logic                v3_reg;
    logic                neg3_reg;
    logic                zero3_reg;
    logic                thok3_reg;
    logic [DIGIT_W-1:0]  thd3_reg;
    logic [REM_W-1:0]    rem3_reg;
    // Stage 4: hundreds digit.
    logic                v4_reg;
    logic                neg4_reg;
    logic                zero4_reg;
    logic                thok4_reg;
    logic [DIGIT_W-1:0]  thd4_reg;
    logic [REM_W-1:0]    rem4_reg;
    logic [DIGIT_W-1:0]  hd4_reg;
    // Stage 5: remainder mod 100.
    logic                v5_reg;
    logic                neg5_reg;
    logic                zero5_reg;
    logic                thok5_reg;
    logic [DIGIT_W-1:0]  thd5_reg;
    logic [DIGIT_W-1:0]  hd5_reg;
    logic [R2_W-1:0]     r2_5_reg;
    // Stage 6: tens digit.
    logic                v6_reg;
    logic                neg6_reg;
    logic                zero6_reg;
    logic                thok6_reg;
    logic [DIGIT_W-1:0]  thd6_reg;
    logic [DIGIT_W-1:0]  hd6_reg;
    logic [R2_W-1:0]     r2_6_reg;
    logic [DIGIT_W-1:0]  td6_reg;
    // Stage 7: token slots and pending mask, drained by the serializer.
    logic                v7_reg;
    logic [NUM_SLOTS-1:0] pend7_reg;
    logic [TOKEN_W-1:0]  tok7_reg [NUM_SLOTS];
    // Output register.
    logic                m_valid_reg;
    logic [TOKEN_W-1:0]  m_token_reg;
    logic                m_last_reg;

    logic                 adv;
    logic                 out_free;
    logic                 emit;
    logic                 consume7;
    logic [NUM_SLOTS-1:0] pick;
    logic [NUM_SLOTS-1:0] rest;
    logic [TOKEN_W-1:0]   pick_token;

    logic [VALUE_W-1:0]   in_value;
    logic                 neg1_next;
    logic [VALUE_W-1:0]   mag1_next;
    logic [2*VALUE_W-1:0] prod2_next;
    logic [THOUS_W+9:0]   th_x1000;
    logic [REM_W-1:0]     rem3_next;
    logic [REM_W+5:0]     prod4_next;
    logic [R2_W+3:0]      hd_x100;
    logic [R2_W-1:0]      r2_5_next;
    logic [R2_W+7:0]      prod6_next;
    logic [R2_W-1:0]      td_x10;
    logic                 tens7_next;
    logic [UNIT_W-1:0]    unit7_next;
    logic [R2_W-1:0]      unit_diff;
    logic [NUM_SLOTS-1:0] pend7_next;

    // ---------------- arithmetic ----------------
    always_comb begin
        in_value   = s_tdata[VALUE_W-1:0];
        neg1_next  = in_value[VALUE_W-1];
        // The most negative pattern negates to 2^20, which fits unsigned.
        mag1_next  = neg1_next ? (~in_value + VALUE_W'(1)) : in_value;

        prod2_next = {{VALUE_W{1'b0}}, mag1_reg} * {{VALUE_W{1'b0}}, RECIP_1000};

        th_x1000   = {{REM_W{1'b0}}, th2_reg} * {{THOUS_W{1'b0}}, K_THOUSAND};
        rem3_next  = mag2_reg[REM_W-1:0] - th_x1000[REM_W-1:0];

        prod4_next = {6'b0, rem3_reg} * {{REM_W{1'b0}}, RECIP_100};

        hd_x100    = {{R2_W{1'b0}}, hd4_reg} * {4'b0, K_HUNDRED};
        r2_5_next  = rem4_reg[R2_W-1:0] - hd_x100[R2_W-1:0];

        prod6_next = {8'b0, r2_5_reg} * {{R2_W{1'b0}}, RECIP_10};

        td_x10     = {3'b0, td6_reg} * {3'b0, K_TEN};
        tens7_next = r2_6_reg > {2'b0, K_TEEN_MAX};
        unit_diff  = r2_6_reg - td_x10;
        unit7_next = tens7_next ? unit_diff[UNIT_W-1:0] : r2_6_reg[UNIT_W-1:0];

        pend7_next              = '0;
        pend7_next[SLOT_NEG]    = v6_reg && neg6_reg;
        pend7_next[SLOT_ZERO]   = v6_reg && zero6_reg;
        pend7_next[SLOT_THOUS]  = v6_reg && thok6_reg;
        pend7_next[SLOT_HUND]   = v6_reg && (hd6_reg != '0);
        pend7_next[SLOT_TENS]   = v6_reg && tens7_next;
        pend7_next[SLOT_UNIT]   = v6_reg && (unit7_next != '0);
    end

    // ---------------- serializer control ----------------
    always_comb begin
        pick       = pend7_reg & (~pend7_reg + NUM_SLOTS'(1));
        rest       = pend7_reg & ~pick;
        pick_token = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (pick[i]) begin
                pick_token = pick_token | tok7_reg[i];
            end
        end
        out_free = !m_valid_reg || m_tready;
        emit     = v7_reg && out_free && (pend7_reg != '0);
        // A value with no tokens left (or none at all) leaves stage 7 here.
        consume7 = v7_reg && out_free && (rest == '0);
        adv      = !v7_reg || consume7;
    end

    // No beat is taken while reset is held.
    assign s_tready = aresetn && adv;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-TOKEN_W){1'b0}}, m_token_reg};
    assign m_tlast  = m_last_reg;

    // ---------------- pipeline valid bits and control ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            pend7_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                v1_reg    <= s_tvalid;
                v2_reg    <= v1_reg;
                v3_reg    <= v2_reg;
                v4_reg    <= v3_reg;
                v5_reg    <= v4_reg;
                v6_reg    <= v5_reg;
                v7_reg    <= v6_reg;
                pend7_reg <= pend7_next;
            end else if (emit) begin
                pend7_reg <= rest;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- pipeline payload ----------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            neg1_reg  <= neg1_next;
            mag1_reg  <= mag1_next;

            neg2_reg  <= neg1_reg;
            mag2_reg  <= mag1_reg;
            th2_reg   <= prod2_next[RECIP_1000_SHIFT +: THOUS_W];

            neg3_reg  <= neg2_reg;
            zero3_reg <= (mag2_reg == '0);
            thok3_reg <= (th2_reg >= THOUS_W'(1)) && (th2_reg <= THOUS_W'(9));
            thd3_reg  <= th2_reg[DIGIT_W-1:0];
            rem3_reg  <= rem3_next;

            neg4_reg  <= neg3_reg;
            zero4_reg <= zero3_reg;
            thok4_reg <= thok3_reg;
            thd4_reg  <= thd3_reg;
            rem4_reg  <= rem3_reg;
            hd4_reg   <= prod4_next[RECIP_100_SHIFT +: DIGIT_W];

            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
            thok5_reg <= thok4_reg;
            thd5_reg  <= thd4_reg;
            hd5_reg   <= hd4_reg;
            r2_5_reg  <= r2_5_next;

            neg6_reg  <= neg5_reg;
            zero6_reg <= zero5_reg;
            thok6_reg <= thok5_reg;
            thd6_reg  <= thd5_reg;
            hd6_reg   <= hd5_reg;
            r2_6_reg  <= r2_5_reg;
            td6_reg   <= prod6_next[RECIP_10_SHIFT +: DIGIT_W];

            tok7_reg[SLOT_NEG]   <= TOK_NEGATIVE;
            tok7_reg[SLOT_ZERO]  <= TOK_ZERO;
            tok7_reg[SLOT_THOUS] <= TOK_THOUSAND_BASE + {2'b0, thd6_reg};
            tok7_reg[SLOT_HUND]  <= TOK_HUNDRED_BASE + {2'b0, hd6_reg};
            tok7_reg[SLOT_TENS]  <= TOK_TENS_BASE + {2'b0, td6_reg};
            tok7_reg[SLOT_UNIT]  <= TOK_UNIT_BASE + {1'b0, unit7_next};
        end
        if (emit) begin
            m_token_reg <= pick_token;
            m_last_reg  <= (rest == '0);
        end
    end

    // ---------------- assertions ----------------
    a_token_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_token_reg <= TOK_MAX))
        else $error("token code out of range");

    a_pend_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        !v7_reg |-> (pend7_reg == '0))
        else $error("pending tokens in an empty serializer stage");

    a_more_tokens_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && (rest != '0)) |=> (v7_reg && (pend7_reg != '0)))
        else $error("value left the serializer before its last token");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v7_reg && m_valid_reg && !m_tready) || (v7_reg && (rest != '0)))
        else $error("input stalled without a busy serializer");

endmodule
